// ----- rtl/pes_pkg.sv -----
// Shared types, codes and lookup functions of the priority effect scheduler.
package pes_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned EFF_W    = 3;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned NUM_FX   = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [EFF_W-1:0] EFF_NULL = 3'd0;

  typedef enum logic [CMD_W-1:0] {
    OP_START   = 2'd0,
    OP_RESTART = 2'd1,
    OP_EXIT    = 2'd2,
    OP_NONE    = 2'd3
  } pes_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRIO_ONE   = 3'd0,
    CFG_PRIO_TWO   = 3'd1,
    CFG_PRIO_THREE = 3'd2,
    CFG_PRIO_FOUR  = 3'd3,
    CFG_QMASK      = 3'd4
  } pes_cfg_idx_e;

  localparam logic [PRIO_W-1:0] RST_PRIO_ONE   = 8'd1;
  localparam logic [PRIO_W-1:0] RST_PRIO_TWO   = 8'd10;
  localparam logic [PRIO_W-1:0] RST_PRIO_THREE = 8'd100;
  localparam logic [PRIO_W-1:0] RST_PRIO_FOUR  = 8'd250;
  localparam logic [NUM_FX-1:0] RST_QMASK      = 4'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } pes_state_e;

  typedef struct packed {
    logic [NUM_FX-1:0][PRIO_W-1:0] prio;
    logic [NUM_FX-1:0]             queued;
  } pes_cfg_t;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic rd;
    logic finish;
  } pes_cmd_t;

  typedef struct packed {
    logic needs_scan;
    logic last_rd;
    logic out_free;
  } pes_sts_t;

  typedef struct packed {
    logic              launch;
    logic [EFF_W-1:0]  launch_id;
    logic              kill;
    logic              queue_full;
    logic [EFF_W-1:0]  active_id;
    logic [PRIO_W-1:0] active_prio;
  } pes_res_t;

  // Unknown and null identifiers have priority zero.
  function automatic logic [PRIO_W-1:0] prio_of(pes_cfg_t cfg, logic [EFF_W-1:0] e);
    logic [PRIO_W-1:0] p;
    case (e)
      3'd1:    p = cfg.prio[0];
      3'd2:    p = cfg.prio[1];
      3'd3:    p = cfg.prio[2];
      3'd4:    p = cfg.prio[3];
      default: p = '0;
    endcase
    return p;
  endfunction

  // Unknown and null identifiers are plain effects.
  function automatic logic is_queued(pes_cfg_t cfg, logic [EFF_W-1:0] e);
    logic q;
    case (e)
      3'd1:    q = cfg.queued[0];
      3'd2:    q = cfg.queued[1];
      3'd3:    q = cfg.queued[2];
      3'd4:    q = cfg.queued[3];
      default: q = 1'b0;
    endcase
    return q;
  endfunction

endpackage

// ----- rtl/pes_if.sv -----
// Channel interfaces of the priority effect scheduler: command, result and configuration.
interface pes_cmd_if import pes_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [EFF_W-1:0] effect;
  modport source (output valid, cmd, effect, input ready);
  modport sink (input valid, cmd, effect, output ready);
endinterface

interface pes_res_if import pes_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              launch;
  logic [EFF_W-1:0]  launch_id;
  logic              kill;
  logic              queue_full;
  logic [EFF_W-1:0]  active_id;
  logic [PRIO_W-1:0] active_prio;
  modport source (output valid, launch, launch_id, kill, queue_full, active_id, active_prio,
                  input ready);
  modport sink (input valid, launch, launch_id, kill, queue_full, active_id, active_prio,
                output ready);
endinterface

interface pes_cfg_if import pes_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/pes_cfg.sv -----
// Configuration register file: effect priorities and the queued-type mask.
module pes_cfg import pes_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  pes_cfg_if.sink       cfg_in,
  output pes_cfg_t      cfg_o
);

  pes_cfg_t cfg_q;

  assign cfg_in.ready = 1'b1;
  assign cfg_o        = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prio[0] <= RST_PRIO_ONE;
      cfg_q.prio[1] <= RST_PRIO_TWO;
      cfg_q.prio[2] <= RST_PRIO_THREE;
      cfg_q.prio[3] <= RST_PRIO_FOUR;
      cfg_q.queued  <= RST_QMASK;
    end else if (cfg_in.valid) begin
      // Writes to indexes beyond the register list are dropped.
      case (cfg_in.index)
        CFG_PRIO_ONE:   cfg_q.prio[0] <= cfg_in.data;
        CFG_PRIO_TWO:   cfg_q.prio[1] <= cfg_in.data;
        CFG_PRIO_THREE: cfg_q.prio[2] <= cfg_in.data;
        CFG_PRIO_FOUR:  cfg_q.prio[3] <= cfg_in.data;
        CFG_QMASK:      cfg_q.queued  <= cfg_in.data[NUM_FX-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/pes_ctrl.sv -----
// Controller state machine that sequences the accept, queue scan and result commit.
module pes_ctrl import pes_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pes_sts_t sts_i,
  output pes_cmd_t cmd_o
);

  pes_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.scan_clr = 1'b1;
        state_d        = sts_i.needs_scan ? ST_SCAN : ST_FIN;
      end
      ST_SCAN: begin
        cmd_o.rd = 1'b1;
        if (sts_i.last_rd) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/pes_dp.sv -----
// Datapath: slot memory, one-slot-per-cycle scan, scheduler state and result register.
module pes_dp import pes_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pes_cmd_t         cmd_i,
  output pes_sts_t         sts_o,
  input  pes_cfg_t         cfg_i,
  input  logic [CMD_W-1:0] in_cmd_i,
  input  logic [EFF_W-1:0] in_effect_i,
  input  logic             res_ready_i,
  output logic             res_valid_o,
  output pes_res_t         res_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  pes_op_e           op_q;
  logic [EFF_W-1:0]  eff_q;
  logic [EFF_W-1:0]  active_q, active_d;
  logic [PRIO_W-1:0] cur_prio_q, cur_prio_d;

  logic [EFF_W-1:0]       mem_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] slot_vld_q;

  logic [AW-1:0]     rd_addr_q;
  logic [AW-1:0]     proc_addr_q;
  logic              rd_pend_q;
  logic [EFF_W-1:0]  rd_data_q;
  logic              rd_vld_q;
  logic              found_q;
  logic [EFF_W-1:0]  best_id_q;
  logic [PRIO_W-1:0] best_p_q;

  pes_res_t res_q, res_d;
  logic     res_valid_q;

  logic [EFF_W-1:0]  slot_v;
  logic [EFF_W-1:0]  eff_v;
  logic [PRIO_W-1:0] eff_p;
  logic              is_ins, is_exit, take, better, wr_en;
  logic [EFF_W-1:0]  wr_data;
  logic              q_eff;

  // Per-slot scan step: an insert claims the first slot that already holds the
  // effect or is empty; an exit clears every slot holding the active effect.
  always_comb begin
    slot_v  = rd_vld_q ? rd_data_q : EFF_NULL;
    q_eff   = is_queued(cfg_i, eff_q);
    is_ins  = (op_q == OP_START || op_q == OP_RESTART) && q_eff;
    is_exit = (op_q == OP_EXIT);
    take    = is_ins && !found_q && (slot_v == eff_q || slot_v == EFF_NULL);
    if (take) begin
      eff_v = eff_q;
    end else if (is_exit && slot_v == active_q) begin
      eff_v = EFF_NULL;
    end else begin
      eff_v = slot_v;
    end
    eff_p   = prio_of(cfg_i, eff_v);
    better  = (eff_v != EFF_NULL) && (eff_p > best_p_q);
    wr_en   = rd_pend_q && ((take && slot_v == EFF_NULL) ||
              (is_exit && slot_v == active_q && active_q != EFF_NULL));
    wr_data = is_exit ? EFF_NULL : eff_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[proc_addr_q] <= wr_data;
    end
    rd_data_q   <= mem_q[rd_addr_q];
    rd_vld_q    <= slot_vld_q[rd_addr_q];
    proc_addr_q <= rd_addr_q;
    if (cmd_i.load) begin
      op_q  <= pes_op_e'(in_cmd_i);
      eff_q <= in_effect_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
    end else if (wr_en) begin
      slot_vld_q[proc_addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q <= '0;
      rd_pend_q <= 1'b0;
      found_q   <= 1'b0;
      best_id_q <= EFF_NULL;
      best_p_q  <= '0;
    end else begin
      rd_pend_q <= cmd_i.rd;
      if (cmd_i.scan_clr) begin
        rd_addr_q <= '0;
        found_q   <= 1'b0;
        best_id_q <= EFF_NULL;
        best_p_q  <= '0;
      end else begin
        if (cmd_i.rd) begin
          rd_addr_q <= rd_addr_q + AW'(1);
        end
        if (rd_pend_q) begin
          if (take) begin
            found_q <= 1'b1;
          end
          if (better) begin
            best_id_q <= eff_v;
            best_p_q  <= eff_p;
          end
        end
      end
    end
  end

  // Commit of one command once the scan, if any, is done.
  always_comb begin
    active_d        = active_q;
    cur_prio_d      = cur_prio_q;
    res_d           = '0;
    res_d.kill      = (op_q == OP_RESTART) && q_eff && (eff_q == active_q);
    case (op_q)
      OP_START, OP_RESTART: begin
        if (q_eff) begin
          if (!found_q) begin
            res_d.queue_full = 1'b1;
          end else begin
            cur_prio_d = best_p_q;
            if (best_id_q == eff_q) begin
              active_d        = eff_q;
              res_d.launch    = 1'b1;
              res_d.launch_id = eff_q;
            end
          end
        end else if (prio_of(cfg_i, eff_q) > cur_prio_q) begin
          active_d        = eff_q;
          res_d.launch    = 1'b1;
          res_d.launch_id = eff_q;
        end
      end
      OP_EXIT: begin
        active_d   = best_id_q;
        cur_prio_d = best_p_q;
        if (best_id_q != EFF_NULL) begin
          res_d.launch    = 1'b1;
          res_d.launch_id = best_id_q;
        end
      end
      default: ;
    endcase
    res_d.active_id   = active_d;
    res_d.active_prio = cur_prio_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= EFF_NULL;
      cur_prio_q  <= '0;
      res_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      active_q    <= active_d;
      cur_prio_q  <= cur_prio_d;
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  assign sts_o.needs_scan = is_ins || is_exit;
  assign sts_o.last_rd    = (rd_addr_q == AW'(QUEUE_DEPTH - 1));
  assign sts_o.out_free   = !res_valid_q || res_ready_i;
  assign res_valid_o      = res_valid_q;
  assign res_o            = res_q;

endmodule

// ----- rtl/priority_effect_scheduler.sv -----
// Top level of the priority effect scheduler: configuration, controller and datapath.
//
//   Channel   Direction  Payload                                     Transfer when
//   cmd_in    in         cmd, effect                                 valid && ready
//   res_out   out        launch, launch_id, kill, queue_full,        valid && ready
//                        active_id, active_prio
//   cfg_in    in         index, data                                 valid && ready
//
// A start or restart of a queued-type effect and an exit scan the queue between the command
// transfer and the result register: the slot memory has one read port, so the scan reads
// one slot per cycle, and a write-back of the slot under test rides along. Any other
// command skips the scan. The block holds one command at a time; cmd_in is
// ready again the cycle after its result is written, even while that result waits.
// Reset clears the slot valid bits at once, so no clearing pass follows reset.
// A stalled result register holds the next command at its commit step until it drains.
module priority_effect_scheduler import pes_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pes_cmd_if.sink   cmd_in,
  pes_res_if.source res_out,
  pes_cfg_if.sink   cfg_in
);

  pes_cfg_t cfg;
  pes_cmd_t cmd;
  pes_sts_t sts;
  pes_res_t res;

  // Register file, always ready; the user issues writes only while idle, not enforced.
  pes_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_in (cfg_in),
    .cfg_o  (cfg)
  );

  // The controller owns the command handshake and steps the datapath.
  pes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_in.valid),
    .in_ready_o (cmd_in.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the queue, the active effect, its priority and the result.
  pes_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_i       (cfg),
    .in_cmd_i    (cmd_in.cmd),
    .in_effect_i (cmd_in.effect),
    .res_ready_i (res_out.ready),
    .res_valid_o (res_out.valid),
    .res_o       (res)
  );

  assign res_out.launch      = res.launch;
  assign res_out.launch_id   = res.launch_id;
  assign res_out.kill        = res.kill;
  assign res_out.queue_full  = res.queue_full;
  assign res_out.active_id   = res.active_id;
  assign res_out.active_prio = res.active_prio;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the priority effect scheduler, with directed and random commands.
module tb_top;
  import pes_pkg::*;

  localparam int unsigned QDEPTH       = 8;
  localparam int unsigned IDLE_PCT     = 23;
  // Twice the length of a queue scan covers any work still in flight.
  localparam int unsigned SETTLE_CYC   = 2 * (QDEPTH + 3);
  localparam int unsigned WATCHDOG_CYC = 2000;
  localparam int unsigned NUM_PHASES   = 14;
  localparam int unsigned PHASE_ITEMS  = 125;
  localparam int unsigned MAX_REPORTS  = 40;

  // Register index that selects no register at all.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  localparam logic [EFF_W-1:0] FX_ONE    = 3'd1;
  localparam logic [EFF_W-1:0] FX_TWO    = 3'd2;
  localparam logic [EFF_W-1:0] FX_THREE  = 3'd3;
  localparam logic [EFF_W-1:0] FX_FOUR   = 3'd4;
  localparam logic [EFF_W-1:0] FX_BAD_LO = 3'd5;
  localparam logic [EFF_W-1:0] FX_BAD_HI = 3'd7;

  // One command waiting to be sent. A command marked drain is held back until every
  // launch decision already requested has come back.
  typedef struct {
    pes_op_e          op;
    logic [EFF_W-1:0] fx;
    bit               drain;
  } fx_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pes_cmd_if cmd_if ();
  pes_res_if res_if ();
  pes_cfg_if cfg_if ();

  priority_effect_scheduler #(
    .QUEUE_DEPTH(QDEPTH)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_in (cmd_if),
    .res_out(res_if),
    .cfg_in (cfg_if)
  );

  always #10 clk_i = ~clk_i;

  fx_cmd_t     cmd_pending [$];
  pes_res_t    decision_q [$];
  int unsigned n_err;
  int unsigned quiet_cyc;
  bit          no_idle;

  // Behavioral copy of the scheduler state and its registers.
  logic [EFF_W-1:0]  fx_slot [QDEPTH];
  logic [EFF_W-1:0]  run_fx;
  logic [PRIO_W-1:0] run_prio;
  logic [PRIO_W-1:0] prio_tab [NUM_FX];
  logic [NUM_FX-1:0] qmask_cfg;

  // Null and unknown identifiers rank zero and are never queued.
  function automatic logic [PRIO_W-1:0] rank_of(logic [EFF_W-1:0] e);
    logic [PRIO_W-1:0] p;
    p = '0;
    if (e >= FX_ONE && e <= FX_FOUR) begin
      p = prio_tab[int'(e) - 1];
    end
    return p;
  endfunction

  function automatic bit uses_queue(logic [EFF_W-1:0] e);
    bit q;
    q = 1'b0;
    if (e >= FX_ONE && e <= FX_FOUR) begin
      q = qmask_cfg[int'(e) - 1];
    end
    return q;
  endfunction

  // The scan stops at a copy already present or at the first empty slot, so an effect
  // can land in a hole ahead of an older copy of itself.
  function automatic bit slot_insert(logic [EFF_W-1:0] e);
    for (int i = 0; i < QDEPTH; i++) begin
      if (fx_slot[i] == e) begin
        return 1'b1;
      end
      if (fx_slot[i] == EFF_NULL) begin
        fx_slot[i] = e;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void slot_remove(logic [EFF_W-1:0] e);
    for (int i = 0; i < QDEPTH; i++) begin
      if (fx_slot[i] == e) begin
        fx_slot[i] = EFF_NULL;
      end
    end
  endfunction

  // Strict comparison: among equal priorities the earliest slot wins, and an effect of
  // priority zero is never picked. The winner's priority becomes the running priority.
  function automatic logic [EFF_W-1:0] pick_best();
    logic [EFF_W-1:0]  best;
    logic [PRIO_W-1:0] p;
    best = EFF_NULL;
    p    = '0;
    for (int i = 0; i < QDEPTH; i++) begin
      if (fx_slot[i] != EFF_NULL && rank_of(fx_slot[i]) > p) begin
        p    = rank_of(fx_slot[i]);
        best = fx_slot[i];
      end
    end
    run_prio = p;
    return best;
  endfunction

  // Works out the launch decision of one command and advances the scheduler state.
  function automatic pes_res_t schedule_cmd(pes_op_e op, logic [EFF_W-1:0] e);
    pes_res_t r;
    r = '0;
    if (op == OP_RESTART && uses_queue(e) && e == run_fx) begin
      r.kill = 1'b1;
    end
    if (op == OP_START || op == OP_RESTART) begin
      if (uses_queue(e)) begin
        if (!slot_insert(e)) begin
          // Full queue: nothing moves, only the flag (and a kill) is reported.
          r.queue_full = 1'b1;
        end else if (pick_best() == e) begin
          run_fx      = e;
          r.launch    = 1'b1;
          r.launch_id = e;
        end
      end else if (rank_of(e) > run_prio) begin
        // A plain effect takes over but leaves the running priority as it was.
        run_fx      = e;
        r.launch    = 1'b1;
        r.launch_id = e;
      end
    end else if (op == OP_EXIT) begin
      slot_remove(run_fx);
      run_fx = pick_best();
      if (run_fx != EFF_NULL) begin
        r.launch    = 1'b1;
        r.launch_id = run_fx;
      end
    end
    r.active_id   = run_fx;
    r.active_prio = run_prio;
    return r;
  endfunction

  function automatic void queue_cmd(pes_op_e op, logic [EFF_W-1:0] fx, bit drain);
    fx_cmd_t c;
    c.op    = op;
    c.fx    = fx;
    c.drain = drain;
    cmd_pending.push_back(c);
  endfunction

  // Most of the stream is episodes: a run of starts and restarts of real effects that
  // builds up the queue, then a few exits that drain it. The rest is single commands
  // with any code and any identifier. Returns the number of commands added.
  function automatic int unsigned add_episode(bit drain_first);
    int unsigned n_in;
    int unsigned n_out;
    if ($urandom_range(99) < 25) begin
      queue_cmd(pes_op_e'($urandom_range(3)), EFF_W'($urandom_range(7)), drain_first);
      return 1;
    end
    n_in  = $urandom_range(9, 2);
    n_out = $urandom_range(4, 1);
    for (int i = 0; i < n_in; i++) begin
      queue_cmd(($urandom_range(99) < 75) ? OP_START : OP_RESTART,
                EFF_W'($urandom_range(NUM_FX, 1)), drain_first && i == 0);
    end
    for (int i = 0; i < n_out; i++) begin
      // The identifier of an exit is ignored, so it is free to take any value.
      queue_cmd(OP_EXIT, EFF_W'($urandom_range(7)), 1'b0);
    end
    return n_in + n_out;
  endfunction

  // Zero and full scale turn up often, which also makes ties between effects common.
  function automatic logic [PRIO_W-1:0] pick_prio();
    logic [PRIO_W-1:0] p;
    case ($urandom_range(3))
      0:       p = '0;
      1:       p = '1;
      default: p = PRIO_W'($urandom_range(255));
    endcase
    return p;
  endfunction

  function automatic void note_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      n_err++;
      if (n_err <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
    end
  endfunction

  // One register write; the behavioral copy follows at the transfer.
  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_PRIO_ONE:   prio_tab[0] = val;
      CFG_PRIO_TWO:   prio_tab[1] = val;
      CFG_PRIO_THREE: prio_tab[2] = val;
      CFG_PRIO_FOUR:  prio_tab[3] = val;
      CFG_QMASK:      qmask_cfg   = val[NUM_FX-1:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_all(logic [PRIO_W-1:0] p1, logic [PRIO_W-1:0] p2,
                         logic [PRIO_W-1:0] p3, logic [PRIO_W-1:0] p4,
                         logic [CFG_DAT_W-1:0] mask);
    put_reg(CFG_PRIO_ONE, p1);
    put_reg(CFG_PRIO_TWO, p2);
    put_reg(CFG_PRIO_THREE, p3);
    put_reg(CFG_PRIO_FOUR, p4);
    put_reg(CFG_QMASK, mask);
  endtask

  // Waits until every command has been sent and answered, then lets the block settle.
  task automatic wait_quiet();
    while (cmd_pending.size() != 0 || cmd_if.valid || decision_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Command driver. The decision for a command is worked out at its transfer, so the
  // behavioral state always sees commands in the order the block takes them. A new
  // command is offered only when the slot is free; valid is written once per edge.
  always @(posedge clk_i) begin : drive_cmd
    fx_cmd_t nxt;
    if (!rst_ni) begin
      cmd_if.valid  <= 1'b0;
      cmd_if.cmd    <= OP_START;
      cmd_if.effect <= EFF_NULL;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        decision_q.push_back(schedule_cmd(pes_op_e'(cmd_if.cmd), cmd_if.effect));
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (cmd_pending.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT) &&
            !(cmd_pending[0].drain && decision_q.size() != 0)) begin
          nxt = cmd_pending.pop_front();
          cmd_if.valid  <= 1'b1;
          cmd_if.cmd    <= nxt.op;
          cmd_if.effect <= nxt.fx;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each transfer is matched against the oldest outstanding decision.
  always @(posedge clk_i) begin : check_res
    pes_res_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (decision_q.size() == 0) begin
          n_err++;
          $display("%0t: result with no command outstanding, expected none, actual %0d",
                   $time, res_if.active_id);
        end else begin
          want = decision_q.pop_front();
          note_field("launch", 32'(want.launch), 32'(res_if.launch));
          note_field("launch_id", 32'(want.launch_id), 32'(res_if.launch_id));
          note_field("kill", 32'(want.kill), 32'(res_if.kill));
          note_field("queue_full", 32'(want.queue_full), 32'(res_if.queue_full));
          note_field("active_id", 32'(want.active_id), 32'(res_if.active_id));
          note_field("active_prio", 32'(want.active_prio), 32'(res_if.active_prio));
        end
      end
      res_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: too long without a transfer on any channel ends the run.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= WATCHDOG_CYC) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cyc);
      $display("[priority_effect_scheduler] ERROR");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  initial begin : stimulus
    int unsigned n;
    bit          paused;
    bit          pause;

    n_err         = 0;
    quiet_cyc     = 0;
    no_idle       = 1'b0;
    rst_ni        = 1'b0;
    cmd_if.valid  = 1'b0;
    cmd_if.cmd    = OP_START;
    cmd_if.effect = EFF_NULL;
    res_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CFG_PRIO_ONE;
    cfg_if.data   = '0;

    prio_tab[0] = RST_PRIO_ONE;
    prio_tab[1] = RST_PRIO_TWO;
    prio_tab[2] = RST_PRIO_THREE;
    prio_tab[3] = RST_PRIO_FOUR;
    qmask_cfg   = RST_QMASK;
    for (int i = 0; i < QDEPTH; i++) begin
      fx_slot[i] = EFF_NULL;
    end
    run_fx   = EFF_NULL;
    run_prio = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: only effect one is queued type.
    queue_cmd(OP_START, EFF_NULL, 1'b0);     // null effect does nothing
    queue_cmd(OP_RESTART, FX_BAD_LO, 1'b0);  // unknown identifiers act as null
    queue_cmd(OP_START, FX_BAD_HI, 1'b0);
    queue_cmd(OP_NONE, FX_THREE, 1'b0);      // unused command code
    queue_cmd(OP_EXIT, EFF_NULL, 1'b0);      // exit with an empty queue
    queue_cmd(OP_START, FX_ONE, 1'b0);       // queued and best, so it launches
    queue_cmd(OP_START, FX_TWO, 1'b0);       // plain effect beats the running priority
    queue_cmd(OP_RESTART, FX_ONE, 1'b0);     // not active: no kill, relaunch
    queue_cmd(OP_RESTART, FX_ONE, 1'b0);     // active: killed and relaunched
    queue_cmd(OP_START, FX_FOUR, 1'b0);
    queue_cmd(OP_EXIT, EFF_NULL, 1'b0);      // plain effect leaves, queue takes over
    queue_cmd(OP_EXIT, EFF_NULL, 1'b0);      // queue empties
    wait_quiet();

    // All effects queued, effect one at priority zero so it is never picked and never
    // removed. Repeated exits open holes ahead of older copies, which fills the queue
    // with copies of effects one to three; the last start of effect four then finds no
    // free slot. Effect one is also started while it is not the best.
    set_all(8'd0, 8'd10, 8'd20, 8'd30, 8'h0F);
    queue_cmd(OP_START, FX_TWO, 1'b0);
    queue_cmd(OP_START, FX_THREE, 1'b0);
    queue_cmd(OP_START, FX_FOUR, 1'b0);
    queue_cmd(OP_START, FX_ONE, 1'b0);
    queue_cmd(OP_EXIT, EFF_NULL, 1'b0);
    queue_cmd(OP_START, FX_ONE, 1'b0);
    queue_cmd(OP_EXIT, EFF_NULL, 1'b0);
    queue_cmd(OP_START, FX_ONE, 1'b0);
    queue_cmd(OP_EXIT, EFF_NULL, 1'b0);
    queue_cmd(OP_START, FX_ONE, 1'b0);
    queue_cmd(OP_START, FX_THREE, 1'b0);
    queue_cmd(OP_START, FX_FOUR, 1'b0);
    queue_cmd(OP_START, FX_TWO, 1'b0);
    queue_cmd(OP_EXIT, EFF_NULL, 1'b0);
    queue_cmd(OP_START, FX_TWO, 1'b0);
    queue_cmd(OP_EXIT, EFF_NULL, 1'b0);
    queue_cmd(OP_START, FX_TWO, 1'b0);
    queue_cmd(OP_START, FX_THREE, 1'b0);
    queue_cmd(OP_START, FX_FOUR, 1'b0);      // queue full
    queue_cmd(OP_RESTART, FX_FOUR, 1'b0);    // queue full on restart as well
    queue_cmd(OP_RESTART, FX_THREE, 1'b0);   // kill of the active effect
    wait_quiet();

    // Random phases, each under its own settings. The first three pin the extremes:
    // every priority at full scale with all effects queued (ties everywhere), every
    // priority zero with no effect queued, and alternating extremes.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       set_all(8'd255, 8'd255, 8'd255, 8'd255, 8'hFF);
        1:       set_all(8'd0, 8'd0, 8'd0, 8'd0, 8'h00);
        2:       set_all(8'd255, 8'd0, 8'd255, 8'd0, 8'hF5);
        default: set_all(pick_prio(), pick_prio(), pick_prio(), pick_prio(),
                         CFG_DAT_W'($urandom_range(255)));
      endcase
      if (ph == 3) begin
        put_reg(CFG_UNUSED, CFG_DAT_W'($urandom_range(255)));
      end
      // Two phases in a row run without any idle cycle on either side.
      no_idle = (ph == 5 || ph == 6);
      n      = 0;
      paused = 1'b0;
      while (n < PHASE_ITEMS) begin
        // Halfway through, the sender holds off once until all answers are back.
        pause  = !paused && n >= PHASE_ITEMS / 2;
        n      += add_episode(pause);
        paused |= pause;
      end
      wait_quiet();
    end
    no_idle = 1'b0;

    if (decision_q.size() != 0) begin
      n_err++;
      $display("%0t: results outstanding, expected 0, actual %0d", $time, decision_q.size());
    end
    if (n_err == 0) begin
      $display("[priority_effect_scheduler] OK");
    end else begin
      $display("[priority_effect_scheduler] ERROR");
    end
    $finish;
  end

endmodule

// ----- priority_effect_scheduler.f -----
rtl/pes_pkg.sv
rtl/pes_if.sv
rtl/pes_cfg.sv
rtl/pes_ctrl.sv
rtl/pes_dp.sv
rtl/priority_effect_scheduler.sv
tb/tb_top.sv
